// ===== rtl/core/i2c_master_byte_engine_defines.svh =====
// Assertion macros for the I2C master byte engine.
// Included by files that check their own logic; needs a clk and rst in scope.
`ifndef I2C_MASTER_BYTE_ENGINE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define I2CMBE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2cmbe: same-cycle check failed");

// next-cycle implication, disabled in reset
`define I2CMBE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2cmbe: next-cycle check failed");

`endif

// ===== rtl/core/i2cmbe_pkg.sv =====
// Shared types and constants of the I2C master byte engine.
// No dependencies; imported by every module of the block.
package i2cmbe_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_HOLD_TICKS     = 2'd0,
    CFG_HALF_BIT_TICKS = 2'd1,
    CFG_SHORT_TICKS    = 2'd2,
    CFG_ACK_TIMEOUT    = 2'd3
  } cfg_index_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_ST_A    = 4'd1,
    PH_ST_B    = 4'd2,
    PH_SP_A    = 4'd3,
    PH_SP_B    = 4'd4,
    PH_WR_LO   = 4'd5,
    PH_WR_HI   = 4'd6,
    PH_WR_TAIL = 4'd7,
    PH_AK_SET  = 4'd8,
    PH_AK_HI   = 4'd9,
    PH_AK_POLL = 4'd10,
    PH_RD_LO   = 4'd11,
    PH_RD_HI   = 4'd12,
    PH_MA_LO   = 4'd13,
    PH_MA_HI   = 4'd14
  } phase_t;

  localparam logic [7:0] HOLD_TICKS_RST     = 8'd4;
  localparam logic [7:0] HALF_BIT_TICKS_RST = 8'd2;
  localparam logic [7:0] SHORT_TICKS_RST    = 8'd1;
  localparam logic [7:0] ACK_TIMEOUT_RST    = 8'd250;
  localparam logic [7:0] TICK_MAX           = 8'hFF;
  localparam logic [3:0] BITS_PER_BYTE      = 4'd8;

  typedef struct packed {
    logic [7:0] hold_ticks;
    logic [7:0] half_bit_ticks;
    logic [7:0] short_ticks;
    logic [7:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic       cmd_valid;
    op_t        operation;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_error;
  } out_item_t;

endpackage

// ===== rtl/core/i2cmbe_cfg.sv =====
// Configuration register file of the I2C master byte engine.
// Depends on i2cmbe_pkg for the register indexes and reset values.
module i2cmbe_cfg
  import i2cmbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output cfg_t       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_ticks     <= HOLD_TICKS_RST;
      cfg.half_bit_ticks <= HALF_BIT_TICKS_RST;
      cfg.short_ticks    <= SHORT_TICKS_RST;
      cfg.ack_timeout    <= ACK_TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_HOLD_TICKS:     cfg.hold_ticks     <= cfg_data;
        CFG_HALF_BIT_TICKS: cfg.half_bit_ticks <= cfg_data;
        CFG_SHORT_TICKS:    cfg.short_ticks    <= cfg_data;
        CFG_ACK_TIMEOUT:    cfg.ack_timeout    <= cfg_data;
        default:            cfg.hold_ticks     <= cfg.hold_ticks;
      endcase
    end
  end

endmodule

// ===== rtl/core/i2cmbe_core.sv =====
// Bus sequencer of the I2C master byte engine: phase state, counters and
// line levels, advanced by one tick per request. Depends on i2cmbe_pkg.
module i2cmbe_core
  import i2cmbe_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t res,
  output logic      busy
);

  phase_t     phase, phase_next;
  logic [7:0] tick_count, tick_count_next;
  logic [3:0] bit_index, bit_index_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [7:0] poll_count, poll_count_next;
  logic       scl_reg, scl_reg_next;
  logic       sda_reg, sda_reg_next;
  logic       drive_reg, drive_reg_next;
  logic       ack_choice, ack_choice_next;
  logic       error_flag, error_flag_next;
  logic [7:0] rx_hold, rx_hold_next;
  logic       done;

  logic [7:0] limit;
  logic [7:0] tick_inc;
  logic       over;
  logic [3:0] bit_inc;
  logic       bit_last;
  logic [7:0] shift_shl;

  always_comb begin
    unique case (phase)
      PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B:  limit = cfg.hold_ticks;
      PH_WR_LO, PH_WR_HI, PH_WR_TAIL,
      PH_RD_LO, PH_MA_LO, PH_MA_HI:        limit = cfg.half_bit_ticks;
      PH_AK_SET, PH_AK_HI, PH_RD_HI:       limit = cfg.short_ticks;
      default:                             limit = cfg.hold_ticks;
    endcase
  end

  assign tick_inc  = (tick_count != TICK_MAX) ? tick_count + 8'd1 : tick_count;
  assign over      = tick_inc >= limit;
  assign bit_inc   = bit_index + 4'd1;
  assign bit_last  = bit_inc >= BITS_PER_BYTE;
  assign shift_shl = {shift_reg[6:0], 1'b0};

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE: begin
        if (item.cmd_valid) begin
          unique case (item.operation)
            OP_START: phase_next = PH_ST_A;
            OP_STOP:  phase_next = PH_SP_A;
            OP_WRITE: phase_next = PH_WR_LO;
            OP_READ:  phase_next = PH_RD_LO;
            default:  phase_next = PH_IDLE;
          endcase
        end
      end
      PH_ST_A:    if (over) phase_next = PH_ST_B;
      PH_ST_B:    if (over) phase_next = PH_IDLE;
      PH_SP_A:    if (over) phase_next = PH_SP_B;
      PH_SP_B:    if (over) phase_next = PH_IDLE;
      PH_WR_LO:   if (over) phase_next = PH_WR_HI;
      PH_WR_HI:   if (over) phase_next = PH_WR_TAIL;
      PH_WR_TAIL: if (over) phase_next = bit_last ? PH_AK_SET : PH_WR_LO;
      PH_AK_SET:  if (over) phase_next = PH_AK_HI;
      PH_AK_HI:   if (over) phase_next = PH_AK_POLL;
      PH_AK_POLL: begin
        if (!item.sda_in) begin
          phase_next = PH_IDLE;
        end else if (poll_count >= cfg.ack_timeout) begin
          phase_next = PH_SP_A;
        end
      end
      PH_RD_LO:   if (over) phase_next = PH_RD_HI;
      PH_RD_HI:   if (over) phase_next = bit_last ? PH_MA_LO : PH_RD_LO;
      PH_MA_LO:   if (over) phase_next = PH_MA_HI;
      PH_MA_HI:   if (over) phase_next = PH_IDLE;
      default:    phase_next = PH_IDLE;
    endcase
  end

  // counters, line levels and flags
  always_comb begin
    tick_count_next = tick_count;
    bit_index_next  = bit_index;
    shift_reg_next  = shift_reg;
    poll_count_next = poll_count;
    scl_reg_next    = scl_reg;
    sda_reg_next    = sda_reg;
    drive_reg_next  = drive_reg;
    ack_choice_next = ack_choice;
    error_flag_next = error_flag;
    rx_hold_next    = rx_hold;
    done            = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (item.cmd_valid) begin
          bit_index_next  = '0;
          poll_count_next = '0;
          tick_count_next = '0;
          unique case (item.operation)
            OP_START: begin
              scl_reg_next   = 1'b1;
              sda_reg_next   = 1'b1;
              drive_reg_next = 1'b1;
            end
            OP_STOP: begin
              scl_reg_next   = 1'b0;
              sda_reg_next   = 1'b0;
              drive_reg_next = 1'b1;
            end
            OP_WRITE: begin
              error_flag_next = 1'b0;
              shift_reg_next  = item.tx_byte;
              scl_reg_next    = 1'b0;
              sda_reg_next    = item.tx_byte[7];
              drive_reg_next  = 1'b1;
            end
            OP_READ: begin
              ack_choice_next = item.send_ack;
              shift_reg_next  = '0;
              scl_reg_next    = 1'b0;
              drive_reg_next  = 1'b0;
            end
            default: begin
              tick_count_next = tick_count;
            end
          endcase
        end
      end
      PH_ST_A: begin
        tick_count_next = over ? 8'd0 : tick_inc;
        if (over) begin
          scl_reg_next   = 1'b1;
          sda_reg_next   = 1'b0;
          drive_reg_next = 1'b1;
        end
      end
      PH_ST_B: begin
        tick_count_next = over ? 8'd0 : tick_inc;
        if (over) begin
          scl_reg_next   = 1'b0;
          sda_reg_next   = 1'b0;
          drive_reg_next = 1'b1;
          done           = 1'b1;
        end
      end
      PH_SP_A: begin
        tick_count_next = over ? 8'd0 : tick_inc;
        if (over) begin
          scl_reg_next   = 1'b1;
          sda_reg_next   = 1'b1;
          drive_reg_next = 1'b1;
        end
      end
      PH_SP_B: begin
        tick_count_next = over ? 8'd0 : tick_inc;
        done            = over;
      end
      PH_WR_LO, PH_MA_LO: begin
        tick_count_next = over ? 8'd0 : tick_inc;
        if (over) begin
          scl_reg_next   = 1'b1;
          drive_reg_next = 1'b1;
        end
      end
      PH_WR_HI: begin
        tick_count_next = over ? 8'd0 : tick_inc;
        if (over) begin
          scl_reg_next   = 1'b0;
          drive_reg_next = 1'b1;
        end
      end
      PH_WR_TAIL: begin
        tick_count_next = over ? 8'd0 : tick_inc;
        if (over) begin
          shift_reg_next = shift_shl;
          bit_index_next = bit_inc;
          scl_reg_next   = 1'b0;
          if (bit_last) begin
            sda_reg_next   = 1'b1;
            drive_reg_next = 1'b0;
          end else begin
            sda_reg_next   = shift_shl[7];
            drive_reg_next = 1'b1;
          end
        end
      end
      PH_AK_SET: begin
        tick_count_next = over ? 8'd0 : tick_inc;
        if (over) begin
          scl_reg_next   = 1'b1;
          sda_reg_next   = 1'b1;
          drive_reg_next = 1'b0;
        end
      end
      PH_AK_HI: begin
        tick_count_next = over ? 8'd0 : tick_inc;
        if (over) begin
          scl_reg_next    = 1'b1;
          sda_reg_next    = 1'b1;
          drive_reg_next  = 1'b0;
          poll_count_next = '0;
        end
      end
      PH_AK_POLL: begin
        if (!item.sda_in) begin
          tick_count_next = '0;
          scl_reg_next    = 1'b0;
          sda_reg_next    = 1'b1;
          drive_reg_next  = 1'b0;
          done            = 1'b1;
        end else if (poll_count >= cfg.ack_timeout) begin
          tick_count_next = '0;
          error_flag_next = 1'b1;
          scl_reg_next    = 1'b0;
          sda_reg_next    = 1'b0;
          drive_reg_next  = 1'b1;
        end else begin
          poll_count_next = poll_count + 8'd1;
        end
      end
      PH_RD_LO: begin
        tick_count_next = over ? 8'd0 : tick_inc;
        if (over) begin
          scl_reg_next   = 1'b1;
          drive_reg_next = 1'b0;
          shift_reg_next = {shift_reg[6:0], item.sda_in};
        end
      end
      PH_RD_HI: begin
        tick_count_next = over ? 8'd0 : tick_inc;
        if (over) begin
          bit_index_next = bit_inc;
          scl_reg_next   = 1'b0;
          if (bit_last) begin
            sda_reg_next   = ~ack_choice;
            drive_reg_next = 1'b1;
          end else begin
            drive_reg_next = 1'b0;
          end
        end
      end
      PH_MA_HI: begin
        tick_count_next = over ? 8'd0 : tick_inc;
        if (over) begin
          scl_reg_next   = 1'b0;
          drive_reg_next = 1'b1;
          rx_hold_next   = shift_reg;
          done           = 1'b1;
        end
      end
      default: begin
        done = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      bit_index  <= '0;
      shift_reg  <= '0;
      poll_count <= '0;
      scl_reg    <= 1'b1;
      sda_reg    <= 1'b1;
      drive_reg  <= 1'b1;
      ack_choice <= 1'b0;
      error_flag <= 1'b0;
      rx_hold    <= '0;
    end else if (fire) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      bit_index  <= bit_index_next;
      shift_reg  <= shift_reg_next;
      poll_count <= poll_count_next;
      scl_reg    <= scl_reg_next;
      sda_reg    <= sda_reg_next;
      drive_reg  <= drive_reg_next;
      ack_choice <= ack_choice_next;
      error_flag <= error_flag_next;
      rx_hold    <= rx_hold_next;
    end
  end

  always_comb begin
    res.scl_level = scl_reg_next;
    res.sda_level = sda_reg_next;
    res.sda_drive = drive_reg_next;
    res.busy_res  = phase_next != PH_IDLE;
    res.done_res  = done;
    res.rx_byte   = rx_hold_next;
    res.ack_error = error_flag_next;
  end

  assign busy = phase != PH_IDLE;

endmodule

// ===== rtl/core/i2c_master_byte_engine.sv =====
// I2C master byte engine. Each request is one bus timer tick and yields one
// result: the SCL/SDA levels and flags after that tick. One tick is taken per
// clock unless the output register stalls; a request is accepted into an input
// register, stepped through the phase sequencer and captured in the output
// register. The output register stalls the chain only while out_ready is low.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_data.
// Depends on i2cmbe_pkg, i2cmbe_cfg, i2cmbe_core and the assertion macros.
`include "i2c_master_byte_engine_defines.svh"

module i2c_master_byte_engine
  import i2cmbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item
);

  cfg_t      cfg;
  logic      s1_valid;
  in_item_t  s1_item;
  logic      s1_fire;
  logic      out_take;
  out_item_t step_res;
  logic      core_busy;

  i2cmbe_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  i2cmbe_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (s1_fire),
    .item (s1_item),
    .cfg  (cfg),
    .res  (step_res),
    .busy (core_busy)
  );

  assign out_take = !out_valid || out_ready;
  assign s1_fire  = s1_valid && out_take;
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_item <= step_res;
    end
  end

  `I2CMBE_ASSERT_NOW(a_done_not_busy, out_valid, !(out_item.done_res && out_item.busy_res))
  `I2CMBE_ASSERT_NEXT(a_busy_tracks, s1_fire, core_busy == $past(step_res.busy_res))
  `I2CMBE_ASSERT_NEXT(a_stage_holds, s1_valid && !s1_fire, s1_valid)

endmodule
